[hw/rtl/rfm_pkg.sv]
// ----------------------------------------------------------------------------
// rfm_pkg
// Shared types, constants and the sine table builder for the rtty fsk
// stream modulator.
// ----------------------------------------------------------------------------
package rfm_pkg;

    // sizing
    localparam int QUEUE_DEPTH     = 256;
    localparam int SINE_TABLE_BITS = 10;
    localparam int DATA_BITS       = 5;

    localparam int FRAME_CELLS = DATA_BITS + 2;
    localparam int CELL_CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int POS_W       = $clog2(FRAME_CELLS);
    localparam int QUARTER     = 1 << (SINE_TABLE_BITS - 2);
    localparam int QOFF_W      = SINE_TABLE_BITS - 1;
    localparam int MAG_W       = 15;
    localparam int SAMPLE_W    = 16;
    localparam int STEP_W      = 32;
    localparam int LEN_W       = 33;
    localparam int TIME_W      = 34;
    localparam int STOP_W      = 2;
    localparam int CFG_IDX_W   = 2;

    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
    localparam int RQ_DEPTH   = 4;
    localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W   = $clog2(RQ_DEPTH + 1);
    localparam int HOLD_W     = 2;
    localparam int HOLD_CYCLES = 2;

    localparam logic [LEN_W-1:0] ONE_SAMPLE   = LEN_W'(65536);
    localparam logic [63:0]      HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0]      SINE_SCALE   = 64'd131068;
    localparam logic [63:0]      SINE_DIVISOR = 64'd5368709120;

    // register reset values
    localparam logic [STEP_W-1:0] MARK_STEP_RST  = 32'd190141781;
    localparam logic [STEP_W-1:0] SPACE_STEP_RST = 32'd205353124;
    localparam logic [STEP_W-1:0] SPB_RST        = 32'd69212937;
    localparam logic [STOP_W-1:0] STOP_LEN_RST   = 2'd2;

    // request codes on the input channel
    typedef enum logic [2:0] {
        REQ_ENQ_SYMBOL = 3'd0,
        REQ_ENQ_BIT    = 3'd1,
        REQ_START      = 3'd2,
        REQ_STOP       = 3'd3,
        REQ_TICK       = 3'd4
    } req_code_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARK_STEP  = 2'd0,
        CFG_SPACE_STEP = 2'd1,
        CFG_SPB        = 2'd2,
        CFG_STOP_LEN   = 2'd3
    } cfg_idx_t;

    // cell length in bit units
    typedef enum logic [STOP_W-1:0] {
        UNITS_ONE      = 2'd0,
        UNITS_ONE_HALF = 2'd1,
        UNITS_TWO      = 2'd2
    } units_t;

    // decoded command kind
    typedef enum logic [4:0] {
        CMD_ENQ_SYMBOL = 5'b00001,
        CMD_ENQ_BIT    = 5'b00010,
        CMD_START      = 5'b00100,
        CMD_STOP       = 5'b01000,
        CMD_TICK       = 5'b10000
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [DATA_BITS-1:0] symbol;
        logic                 mark;
    } cmd_t;

    // one queued frame: a framed symbol or a single cell
    typedef struct packed {
        logic                 is_symbol;
        logic [DATA_BITS-1:0] data;
        units_t               stop_code;
    } frame_t;

    typedef struct packed {
        logic [STEP_W-1:0] mark_step;
        logic [STEP_W-1:0] space_step;
        logic [STEP_W-1:0] samples_per_bit;
        logic [STOP_W-1:0] stop_length;
    } cfg_t;

    typedef struct packed {
        logic                       fire;
        logic                       complete;
        logic [SINE_TABLE_BITS-1:0] idx;
    } sine_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
        logic                       tx_complete;
    } result_t;

    // quarter wave magnitude by truncated taylor series
    function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] mag;
        x    = (64'(k) * HALF_PI_Q30) / QUARTER;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if ((n % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        if (neg > pos)
            mag = 64'd0;
        else
            mag = ((pos - neg) * SINE_SCALE) / SINE_DIVISOR;
        return mag[MAG_W-1:0];
    endfunction

    // packed quarter wave table, entries 0 to QUARTER inclusive
    function automatic logic [(QUARTER+1)*MAG_W-1:0] build_qtab();
        logic [(QUARTER+1)*MAG_W-1:0] tab;
        tab = '0;
        for (int k = 0; k <= QUARTER; k++)
            tab[k*MAG_W +: MAG_W] = quarter_mag(k);
        return tab;
    endfunction

endpackage

[hw/rtl/rfm_front.sv]
// ----------------------------------------------------------------------------
// rfm_front
// Accepts requests, decodes them into commands and holds them in a short
// queue for the back end. Unknown request codes are dropped here.
// ----------------------------------------------------------------------------
module rfm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [2:0]                   req_type,
    input  logic [rfm_pkg::DATA_BITS-1:0] symbol_code,
    input  logic                         mark_level,
    output logic                         full,
    output logic                         cmd_valid,
    output rfm_pkg::cmd_t                cmd,
    input  logic                         cmd_pop
);
    import rfm_pkg::*;

    cmd_t                 cmdq_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    cmd_t                 dec_cmd;
    logic                 dec_known;
    logic                 enq;
    logic                 deq;

    // request decode
    always_comb
    begin
        dec_cmd.symbol = symbol_code;
        dec_cmd.mark   = mark_level;
        dec_cmd.kind   = CMD_TICK;
        dec_known      = 1'b1;
        unique case (req_type)
            REQ_ENQ_SYMBOL: dec_cmd.kind = CMD_ENQ_SYMBOL;
            REQ_ENQ_BIT:    dec_cmd.kind = CMD_ENQ_BIT;
            REQ_START:      dec_cmd.kind = CMD_START;
            REQ_STOP:       dec_cmd.kind = CMD_STOP;
            REQ_TICK:       dec_cmd.kind = CMD_TICK;
            default:        dec_known    = 1'b0;
        endcase
    end

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cmdq_reg[rd_ptr_reg];
    assign enq       = push && !full && dec_known;
    assign deq       = cmd_pop && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (enq && !deq)
            count_next = count_reg + 1'b1;
        else if (!enq && deq)
            count_next = count_reg - 1'b1;
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (enq)
            cmdq_reg[wr_ptr_reg] <= dec_cmd;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/rfm_frame_fifo.sv]
// ----------------------------------------------------------------------------
// rfm_frame_fifo
// Frame queue with the head entry held in a register so the back end can
// read it with no wait. Frames live in a memory behind the head.
// ----------------------------------------------------------------------------
module rfm_frame_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            push,
    input  rfm_pkg::frame_t push_data,
    input  logic            consume,
    output rfm_pkg::frame_t head
);
    import rfm_pkg::*;

    frame_t                mem [QUEUE_DEPTH];
    frame_t                head_reg;
    logic                  head_valid_reg;
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [CELL_CNT_W-1:0] mem_count_reg;
    logic                  refill;
    logic                  bypass;
    logic                  mem_wr;
    logic                  mem_rd;

    assign head   = head_reg;
    assign refill = !head_valid_reg || consume;
    assign bypass = push && refill && (mem_count_reg == '0);
    assign mem_wr = push && !bypass;
    assign mem_rd = refill && (mem_count_reg != '0);

    // memory write
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[wr_ptr_reg] <= push_data;
    end

    // registered read into the head, or direct load when the queue is dry
    always_ff @(posedge clk)
    begin
        if (mem_rd)
            head_reg <= mem[rd_ptr_reg];
        else if (bypass)
            head_reg <= push_data;
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            mem_count_reg  <= '0;
            head_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            mem_count_reg  <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_wr)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (mem_rd)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (mem_wr && !mem_rd)
                mem_count_reg <= mem_count_reg + 1'b1;
            else if (!mem_wr && mem_rd)
                mem_count_reg <= mem_count_reg - 1'b1;
            if (refill)
                head_valid_reg <= mem_rd || bypass;
        end
    end

endmodule

[hw/rtl/rfm_back.sv]
// ----------------------------------------------------------------------------
// rfm_back
// Executes commands one per cycle while issue_en is high: keeps the cell
// count and frame queue, runs the cell timer, the tail logic and the phase
// accumulator, and issues sine lookups and completion items.
// ----------------------------------------------------------------------------
module rfm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  rfm_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  logic               issue_en,
    input  rfm_pkg::cfg_t      cfg,
    output rfm_pkg::sine_req_t sine_req
);
    import rfm_pkg::*;

    logic                     fire;

    // cell lengths, registered from configuration
    logic [LEN_W-1:0]         spb_ext;
    logic [LEN_W-1:0]         raw_len [3];
    logic [LEN_W-1:0]         len_reg [3];
    logic [LEN_W-1:0]         lenm1_reg [3];

    // control state
    logic [CELL_CNT_W-1:0]    cell_count_reg, cell_count_next;
    logic [STEP_W-1:0]        phase_reg, phase_next;
    logic signed [TIME_W-1:0] time_reg, time_next;
    logic                     level_reg, level_next;
    logic                     running_reg, running_next;
    logic                     payload_reg, payload_next;
    logic                     tail_reg, tail_next;
    logic [POS_W-1:0]         pos_reg, pos_next;

    // frame queue interface
    frame_t                   ff_head;
    frame_t                   ff_push_data;
    logic                     ff_push;
    logic                     ff_clear;
    logic                     pop_cell;

    // current cell of the head frame
    logic                     cell_level;
    units_t                   cell_units;
    logic                     cell_last;
    logic                     data_bit;
    logic                     time_expired;
    logic                     tick_level;
    units_t                   stop_code;

    assign fire    = cmd_valid && issue_en;
    assign cmd_pop = fire;

    function automatic logic [LEN_W-1:0] pick_len(units_t u, logic [LEN_W-1:0] l0,
                                                  logic [LEN_W-1:0] l1,
                                                  logic [LEN_W-1:0] l2);
        logic [LEN_W-1:0] r;
        case (u)
            UNITS_ONE:      r = l0;
            UNITS_ONE_HALF: r = l1;
            default:        r = l2;
        endcase
        return r;
    endfunction

    // cell lengths with a floor of one sample
    assign spb_ext    = LEN_W'(cfg.samples_per_bit);
    assign raw_len[0] = spb_ext;
    assign raw_len[1] = spb_ext + (spb_ext >> 1);
    assign raw_len[2] = spb_ext << 1;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            len_reg[i]   <= (raw_len[i] < ONE_SAMPLE) ? ONE_SAMPLE : raw_len[i];
            lenm1_reg[i] <= len_reg[i] - ONE_SAMPLE;
        end
    end

    // frame queue
    rfm_frame_fifo u_frame_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (ff_clear),
        .push      (ff_push),
        .push_data (ff_push_data),
        .consume   (pop_cell && cell_last),
        .head      (ff_head)
    );

    // stop length 3 counts as two units
    assign stop_code = (cfg.stop_length > STOP_W'(UNITS_TWO)) ? UNITS_TWO
                                                             : units_t'(cfg.stop_length);

    always_comb
    begin
        ff_push_data.is_symbol = (cmd.kind == CMD_ENQ_SYMBOL);
        ff_push_data.data      = (cmd.kind == CMD_ENQ_SYMBOL) ? cmd.symbol
                                                              : DATA_BITS'(cmd.mark);
        ff_push_data.stop_code = stop_code;
    end

    // cell select within the head frame
    always_comb
    begin
        data_bit = 1'b0;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            if (pos_reg == POS_W'(i + 1))
                data_bit = ff_head.data[i];
        end
        cell_units = UNITS_ONE;
        cell_last  = 1'b0;
        if (!ff_head.is_symbol)
        begin
            cell_level = ff_head.data[0];
            cell_last  = 1'b1;
        end
        else if (pos_reg == '0)
            cell_level = 1'b0;
        else if (pos_reg == POS_W'(FRAME_CELLS - 1))
        begin
            cell_level = 1'b1;
            cell_units = ff_head.stop_code;
            cell_last  = 1'b1;
        end
        else
            cell_level = data_bit;
    end

    assign time_expired = time_reg[TIME_W-1] || (time_reg == '0);

    // command execution
    always_comb
    begin
        cell_count_next   = cell_count_reg;
        phase_next        = phase_reg;
        time_next         = time_reg;
        level_next        = level_reg;
        running_next      = running_reg;
        payload_next      = payload_reg;
        tail_next         = tail_reg;
        pos_next          = pos_reg;
        ff_push           = 1'b0;
        ff_clear          = 1'b0;
        pop_cell          = 1'b0;
        tick_level        = level_reg;
        sine_req.fire     = 1'b0;
        sine_req.complete = 1'b0;
        sine_req.idx      = phase_reg[STEP_W-1 -: SINE_TABLE_BITS];
        if (fire)
        begin
            unique case (cmd.kind)
                CMD_ENQ_SYMBOL:
                begin
                    if (cell_count_reg <= CELL_CNT_W'(QUEUE_DEPTH - FRAME_CELLS))
                    begin
                        ff_push         = 1'b1;
                        cell_count_next = cell_count_reg + CELL_CNT_W'(FRAME_CELLS);
                    end
                end
                CMD_ENQ_BIT:
                begin
                    if (cell_count_reg < CELL_CNT_W'(QUEUE_DEPTH))
                    begin
                        ff_push         = 1'b1;
                        cell_count_next = cell_count_reg + 1'b1;
                    end
                end
                CMD_START:
                begin
                    running_next = 1'b1;
                    phase_next   = '0;
                    tail_next    = 1'b0;
                    if (cell_count_reg != '0)
                    begin
                        pop_cell        = 1'b1;
                        cell_count_next = cell_count_reg - 1'b1;
                        level_next      = cell_level;
                        time_next       = $signed(TIME_W'(pick_len(cell_units, len_reg[0],
                                                                   len_reg[1], len_reg[2])));
                        payload_next    = 1'b1;
                    end
                    else
                    begin
                        level_next   = 1'b1;
                        time_next    = $signed(TIME_W'(len_reg[0]));
                        payload_next = 1'b0;
                    end
                end
                CMD_STOP:
                begin
                    running_next    = 1'b0;
                    payload_next    = 1'b0;
                    tail_next       = 1'b0;
                    level_next      = 1'b1;
                    time_next       = '0;
                    cell_count_next = '0;
                    pos_next        = '0;
                    ff_clear        = 1'b1;
                end
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        sine_req.fire = 1'b1;
                        if (!time_expired)
                            time_next = time_reg - $signed(TIME_W'(ONE_SAMPLE));
                        else if (cell_count_reg != '0)
                        begin
                            // next queued cell, less the sample sent now
                            pop_cell        = 1'b1;
                            cell_count_next = cell_count_reg - 1'b1;
                            tick_level      = cell_level;
                            time_next       = time_reg + $signed(TIME_W'(
                                              pick_len(cell_units, lenm1_reg[0],
                                                       lenm1_reg[1], lenm1_reg[2])));
                            payload_next    = 1'b1;
                            tail_next       = 1'b0;
                        end
                        else if (payload_reg && tail_reg)
                        begin
                            // tail mark done
                            sine_req.complete = 1'b1;
                            running_next      = 1'b0;
                            payload_next      = 1'b0;
                            tail_next         = 1'b0;
                        end
                        else if (payload_reg)
                        begin
                            tick_level = 1'b1;
                            time_next  = time_reg + $signed(TIME_W'(lenm1_reg[0]));
                            tail_next  = 1'b1;
                        end
                        // otherwise idle mark holds its time
                        if (!sine_req.complete)
                        begin
                            level_next = tick_level;
                            phase_next = phase_reg + (tick_level ? cfg.mark_step
                                                                 : cfg.space_step);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (pop_cell)
            pos_next = cell_last ? '0 : pos_reg + 1'b1;
    end

    // phase is not reset on stop, only on start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= '0;
            phase_reg      <= '0;
            time_reg       <= '0;
            level_reg      <= 1'b1;
            running_reg    <= 1'b0;
            payload_reg    <= 1'b0;
            tail_reg       <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            cell_count_reg <= cell_count_next;
            phase_reg      <= phase_next;
            time_reg       <= time_next;
            level_reg      <= level_next;
            running_reg    <= running_next;
            payload_reg    <= payload_next;
            tail_reg       <= tail_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

[hw/rtl/rfm_sine.sv]
// ----------------------------------------------------------------------------
// rfm_sine
// Quarter wave table lookup with registered read, followed by the quadrant
// sign. Also carries completion items through the same stage.
// ----------------------------------------------------------------------------
module rfm_sine (
    input  logic               clk,
    input  logic               rst_n,
    input  rfm_pkg::sine_req_t req,
    output logic               res_valid,
    output rfm_pkg::result_t   res
);
    import rfm_pkg::*;

    localparam logic [(QUARTER+1)*MAG_W-1:0] QTAB = build_qtab();

    logic [1:0]                quad;
    logic [SINE_TABLE_BITS-3:0] r;
    logic [QOFF_W-1:0]         off;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic                      complete_reg;
    logic                      valid_reg;
    logic signed [SAMPLE_W-1:0] mag_ext;

    // quadrant fold
    assign quad = req.idx[SINE_TABLE_BITS-1 -: 2];
    assign r    = req.idx[SINE_TABLE_BITS-3:0];
    assign off  = quad[0] ? (QOFF_W'(QUARTER) - QOFF_W'(r)) : QOFF_W'(r);

    // table read
    always_ff @(posedge clk)
    begin
        if (req.fire)
        begin
            mag_reg      <= QTAB[32'(off) * MAG_W +: MAG_W];
            neg_reg      <= quad[1];
            complete_reg <= req.complete;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= req.fire;
    end

    // signed sample
    assign mag_ext          = $signed(SAMPLE_W'(mag_reg));
    assign res_valid        = valid_reg;
    assign res.sample       = complete_reg ? '0 : (neg_reg ? -mag_ext : mag_ext);
    assign res.sample_valid = !complete_reg;
    assign res.tx_complete  = complete_reg;

endmodule

[hw/rtl/rfm_result_q.sv]
// ----------------------------------------------------------------------------
// rfm_result_q
// Small result queue in front of the output channel; reports its fill so
// the back end only issues work that has room.
// ----------------------------------------------------------------------------
module rfm_result_q (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr,
    input  rfm_pkg::result_t            wr_data,
    input  logic                        pop,
    output logic                        empty,
    output rfm_pkg::result_t            rd_data,
    output logic [rfm_pkg::RQ_CNT_W-1:0] count
);
    import rfm_pkg::*;

    result_t             q_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg;
    logic [RQ_PTR_W-1:0] rd_ptr_reg;
    logic [RQ_CNT_W-1:0] count_reg;
    logic                deq;

    assign empty   = (count_reg == '0);
    assign rd_data = q_reg[rd_ptr_reg];
    assign count   = count_reg;
    assign deq     = pop && !empty;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr && !deq)
                count_reg <= count_reg + 1'b1;
            else if (!wr && deq)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hw/rtl/rtty_fsk_stream_modulator.sv]
// ----------------------------------------------------------------------------
// rtty_fsk_stream_modulator
// Continuous-phase fsk modulator for 5-bit rtty symbols, queue interface.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full and are accepted when push is high and
//   full is low: enqueue symbol, enqueue single bit, start, stop, sample tick.
//   Only a tick while running yields an item on the result side, either a
//   sample or the end-of-transmission flag; it is shown while empty is low
//   and taken with pop.
//   Registers are written through cfg_valid/cfg_ready (always ready); the user
//   must write them only while the block is idle, which the block does not
//   enforce. After a write the back end holds while the cell lengths settle.
//   Throughput: one request per cycle while full is low; the back end executes
//   one command a cycle, when not held, from a four entry command queue.
//   A tick goes through the command queue, then the sine table read, into the
//   output queue; empty drops once it is written there.
//   If the receiver stalls, the four entry result queue fills, the back end
//   stops issuing and full rises once the command queue is full; nothing is
//   dropped.
//   Reset clears queues and state and loads the register defaults; the
//   frame memory needs no clearing pass.
// ----------------------------------------------------------------------------
module rtty_fsk_stream_modulator (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               push,
    output logic                               full,
    input  logic [2:0]                         req_type,
    input  logic [rfm_pkg::DATA_BITS-1:0]      symbol_code,
    input  logic                               mark_level,
    // result channel
    output logic                               empty,
    input  logic                               pop,
    output logic signed [rfm_pkg::SAMPLE_W-1:0] sample,
    output logic                               sample_valid,
    output logic                               tx_complete,
    // configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfm_pkg::STEP_W-1:0]         cfg_data
);
    import rfm_pkg::*;

    cfg_t                cfg_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic                cfg_wr;
    logic                issue_en;
    logic                cmd_valid;
    cmd_t                cmd;
    logic                cmd_pop;
    sine_req_t           sine_req;
    logic                res_valid;
    result_t             res;
    result_t             out_item;
    logic [RQ_CNT_W-1:0] rq_count;
    logic [RQ_CNT_W-1:0] occupancy;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mark_step       <= MARK_STEP_RST;
            cfg_reg.space_step      <= SPACE_STEP_RST;
            cfg_reg.samples_per_bit <= SPB_RST;
            cfg_reg.stop_length     <= STOP_LEN_RST;
            hold_reg                <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_MARK_STEP:  cfg_reg.mark_step       <= cfg_data;
                    CFG_SPACE_STEP: cfg_reg.space_step      <= cfg_data;
                    CFG_SPB:        cfg_reg.samples_per_bit <= cfg_data;
                    CFG_STOP_LEN:   cfg_reg.stop_length     <= cfg_data[STOP_W-1:0];
                    default: ;
                endcase
                hold_reg <= HOLD_W'(HOLD_CYCLES);
            end
            else if (hold_reg != '0)
                hold_reg <= hold_reg - 1'b1;
        end
    end

    // issue only with room for a result downstream
    assign occupancy = rq_count + RQ_CNT_W'(res_valid);
    assign issue_en  = (hold_reg == '0) && !cfg_wr && (occupancy < RQ_CNT_W'(RQ_DEPTH));

    rfm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .req_type    (req_type),
        .symbol_code (symbol_code),
        .mark_level  (mark_level),
        .full        (full),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    rfm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .issue_en  (issue_en),
        .cfg       (cfg_reg),
        .sine_req  (sine_req)
    );

    rfm_sine u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (sine_req),
        .res_valid (res_valid),
        .res       (res)
    );

    rfm_result_q u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_data (res),
        .pop     (pop),
        .empty   (empty),
        .rd_data (out_item),
        .count   (rq_count)
    );

    assign sample       = out_item.sample;
    assign sample_valid = out_item.sample_valid;
    assign tx_complete  = out_item.tx_complete;

    // result queue never overflows
    a_rq_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (rq_count < RQ_CNT_W'(RQ_DEPTH)))
        else $error("result queue written while full");

    // a register write holds the back end on the next cycle
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !cmd_pop)
        else $error("command issued right after a register write");

    // a completion item carries no sample
    a_complete_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tx_complete) |-> (!sample_valid && (sample == '0)))
        else $error("completion item with sample data");

    // back end only issues with room in the pipeline
    a_issue_credit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (occupancy < RQ_CNT_W'(RQ_DEPTH)))
        else $error("command issued without result room");

endmodule

[sim/rtty_fsk_stream_modulator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtty_fsk_stream_modulator_test
// Self-checking bench for the rtty fsk modulator. Requests go in through
// push/full under bursty traffic and samples come out through empty/pop
// under a changing stall pattern. A scoreboard keeps its own model of the
// cell queue, the bit timing and the phase accumulator and compares every
// sample and completion flag, field by field, in order.
// ----------------------------------------------------------------------------

localparam int MAX_PRINTED = 40;

// ----------------------------------------------------------------------------
// scoreboard: modulator model plus the queue of samples it predicts
// ----------------------------------------------------------------------------
class fsk_scoreboard;

    localparam int DEPTH    = rfm_pkg::QUEUE_DEPTH;
    localparam int QSIZE    = 1 << (rfm_pkg::SINE_TABLE_BITS - 2);
    localparam int ONE_TICK = 65536;

    // modulator state
    logic [2:0]  cells [DEPTH];
    int unsigned head;
    int unsigned count;
    logic [31:0] phase;
    longint      time_left;
    bit          level;
    bit          running;
    bit          payload_begun;
    bit          tail_pending;

    // register copies
    logic [31:0] mark_step;
    logic [31:0] space_step;
    logic [31:0] samples_per_bit;
    logic [1:0]  stop_length;

    logic [14:0] mag_lut [QSIZE + 1];
    rfm_pkg::result_t expected_out [$];

    int errors;
    int printed;
    int samples_checked;
    int completions_checked;
    int frames_dropped;
    int cells_dropped;

    function new();
        for (int k = 0; k <= QSIZE; k++)
            mag_lut[k] = 15'(taylor_mag(k));
        head            = 0;
        count           = 0;
        phase           = '0;
        time_left       = 0;
        level           = 1'b1;
        running         = 1'b0;
        payload_begun   = 1'b0;
        tail_pending    = 1'b0;
        mark_step       = rfm_pkg::MARK_STEP_RST;
        space_step      = rfm_pkg::SPACE_STEP_RST;
        samples_per_bit = rfm_pkg::SPB_RST;
        stop_length     = rfm_pkg::STOP_LEN_RST;
        errors          = 0;
        printed         = 0;
    endfunction

    // quarter wave magnitude from a truncated sine series in q30
    function longint unsigned taylor_mag(int k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        x    = (longint'(k) * 64'd1686629713) / QSIZE;
        term = x;
        pos  = x;
        neg  = 0;
        for (int n = 1; n <= 6; n++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        if (neg > pos)
            return 0;
        return ((pos - neg) * 64'd131068) / (64'd5 << 30);
    endfunction

    // signed sample for a phase, quadrant folded onto the quarter table
    function logic signed [15:0] sine_at(logic [31:0] ph);
        int unsigned idx;
        int unsigned quad;
        int unsigned r;
        int unsigned off;
        int          m;
        idx  = ph >> (32 - rfm_pkg::SINE_TABLE_BITS);
        quad = (idx >> (rfm_pkg::SINE_TABLE_BITS - 2)) & 3;
        r    = idx & (QSIZE - 1);
        off  = (quad & 1) ? (QSIZE - r) : r;
        m    = int'(mag_lut[off]);
        return 16'((quad & 2) ? -m : m);
    endfunction

    // cell duration in q16.16 samples, never shorter than one sample
    function longint cell_len(logic [1:0] units);
        longint s;
        longint len;
        s = longint'(samples_per_bit);
        if (units == rfm_pkg::UNITS_ONE)
            len = s;
        else if (units == rfm_pkg::UNITS_ONE_HALF)
            len = s + (s >> 1);
        else
            len = 2 * s;
        if (len < ONE_TICK)
            len = ONE_TICK;
        return len;
    endfunction

    function void queue_cell(bit mark, logic [1:0] units);
        cells[(head + count) % DEPTH] = {units, mark};
        count++;
    endfunction

    function logic [2:0] take_cell();
        logic [2:0] c;
        c     = cells[head];
        head  = (head + 1) % DEPTH;
        count--;
        return c;
    endfunction

    function void apply_register(rfm_pkg::cfg_idx_t idx, logic [31:0] data);
        case (idx)
            rfm_pkg::CFG_MARK_STEP:  mark_step       = data;
            rfm_pkg::CFG_SPACE_STEP: space_step      = data;
            rfm_pkg::CFG_SPB:        samples_per_bit = data;
            default:                 stop_length     = data[1:0];
        endcase
    endfunction

    // update the model for one accepted request, returns 0 if it was ignored
    function bit predict_request(logic [2:0] req, logic [rfm_pkg::DATA_BITS-1:0] sym,
                                 bit lvl);
        rfm_pkg::result_t r;
        logic [2:0]       c;
        bit               idle_hold;
        case (req)
            rfm_pkg::REQ_ENQ_SYMBOL:
            begin
                if (count + rfm_pkg::DATA_BITS + 2 <= DEPTH)
                begin
                    queue_cell(1'b0, rfm_pkg::UNITS_ONE);
                    for (int i = 0; i < rfm_pkg::DATA_BITS; i++)
                        queue_cell(sym[i], rfm_pkg::UNITS_ONE);
                    queue_cell(1'b1, (stop_length > 2) ? rfm_pkg::UNITS_TWO : stop_length);
                end
                else
                    frames_dropped++;
                return 1;
            end
            rfm_pkg::REQ_ENQ_BIT:
            begin
                if (count < DEPTH)
                    queue_cell(lvl, rfm_pkg::UNITS_ONE);
                else
                    cells_dropped++;
                return 1;
            end
            rfm_pkg::REQ_START:
            begin
                running      = 1'b1;
                phase        = '0;
                tail_pending = 1'b0;
                if (count > 0)
                begin
                    c             = take_cell();
                    level         = c[0];
                    time_left     = cell_len(c[2:1]);
                    payload_begun = 1'b1;
                end
                else
                begin
                    level         = 1'b1;
                    time_left     = cell_len(rfm_pkg::UNITS_ONE);
                    payload_begun = 1'b0;
                end
                return 1;
            end
            rfm_pkg::REQ_STOP:
            begin
                running       = 1'b0;
                payload_begun = 1'b0;
                tail_pending  = 1'b0;
                level         = 1'b1;
                time_left     = 0;
                head          = 0;
                count         = 0;
                return 1;
            end
            rfm_pkg::REQ_TICK:
            begin
                if (!running)
                    return 0;
                idle_hold = 1'b0;
                // load cells until one has time left, carrying the fraction
                while (time_left <= 0 && !idle_hold)
                begin
                    if (count > 0)
                    begin
                        c             = take_cell();
                        level         = c[0];
                        time_left    += cell_len(c[2:1]);
                        payload_begun = 1'b1;
                        tail_pending  = 1'b0;
                    end
                    else if (payload_begun)
                    begin
                        if (tail_pending)
                        begin
                            running        = 1'b0;
                            payload_begun  = 1'b0;
                            tail_pending   = 1'b0;
                            r.sample       = '0;
                            r.sample_valid = 1'b0;
                            r.tx_complete  = 1'b1;
                            expected_out.push_back(r);
                            return 1;
                        end
                        level        = 1'b1;
                        time_left   += cell_len(rfm_pkg::UNITS_ONE);
                        tail_pending = 1'b1;
                    end
                    else
                        idle_hold = 1'b1;
                end
                r.sample       = sine_at(phase);
                r.sample_valid = 1'b1;
                r.tx_complete  = 1'b0;
                expected_out.push_back(r);
                phase += level ? mark_step : space_step;
                if (!idle_hold)
                    time_left -= ONE_TICK;
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    task report_mismatch(string what);
        errors++;
        if (printed < MAX_PRINTED)
        begin
            printed++;
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    task check_result(logic signed [15:0] s, logic v, logic c);
        rfm_pkg::result_t e;
        if (expected_out.size() == 0)
        begin
            report_mismatch($sformatf("unexpected item sample %0d valid %b complete %b",
                                      s, v, c));
            return;
        end
        e = expected_out.pop_front();
        if (s !== e.sample)
            report_mismatch($sformatf("sample %0d, expected %0d", s, e.sample));
        if (v !== e.sample_valid)
            report_mismatch($sformatf("sample_valid %b, expected %b", v, e.sample_valid));
        if (c !== e.tx_complete)
            report_mismatch($sformatf("tx_complete %b, expected %b", c, e.tx_complete));
        if (e.tx_complete)
            completions_checked++;
        else
            samples_checked++;
    endtask

    function int pending();
        return expected_out.size();
    endfunction

    task flush_missing();
        while (expected_out.size() != 0)
        begin
            void'(expected_out.pop_front());
            report_mismatch("expected item never arrived");
        end
    endtask

endclass

// ----------------------------------------------------------------------------
// top of the bench
// ----------------------------------------------------------------------------
module rtty_fsk_stream_modulator_test;

    import rfm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int ITEM_TARGET   = 1800;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRESSURE_HOLD = 400;
    localparam int SLOW_PHASE    = 2;
    localparam int TIMEOUT_NS    = 3_000_000;

    localparam logic [2:0]  REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0]  REQ_UNKNOWN_HI = 3'd7;
    localparam logic [31:0] SPB_ONE_SAMPLE = 32'd65536;
    localparam logic [31:0] SPB_MAX        = 32'hFFFF_FFFF;
    localparam logic [31:0] STEP_MAX       = 32'hFFFF_FFFF;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           push        = 1'b0;
    logic                           full;
    logic [2:0]                     req_type    = '0;
    logic [DATA_BITS-1:0]           symbol_code = '0;
    logic                           mark_level  = 1'b0;
    logic                           empty;
    logic                           pop         = 1'b0;
    logic signed [SAMPLE_W-1:0]     sample;
    logic                           sample_valid;
    logic                           tx_complete;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index   = '0;
    logic [STEP_W-1:0]              cfg_data    = '0;

    fsk_scoreboard sb;

    int       burst_left   = 0;
    bit       gaps_off     = 1'b0;
    int       items_done   = 0;
    int       reg_writes   = 0;
    int       phase_no     = 0;
    int       hold_left    = 0;
    rx_mode_t rx_mode      = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_count     = 0;

    rtty_fsk_stream_modulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .symbol_code  (symbol_code),
        .mark_level   (mark_level),
        .empty        (empty),
        .pop          (pop),
        .sample       (sample),
        .sample_valid (sample_valid),
        .tx_complete  (tx_complete),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // receiver: long hold-off when requested, else a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 300);
            end
            rx_mode_left--;
            rx_count++;
            case (rx_mode)
                RX_ALWAYS:  pop <= 1'b1;
                RX_COIN:    pop <= 1'($urandom_range(0, 1));
                RX_PATTERN: pop <= (rx_count % 7) < 3;
                default:    pop <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(sample, sample_valid, tx_complete);
    end

    // one request item, with burst gaps in front of it
    task offer_request(logic [2:0] req, logic [DATA_BITS-1:0] sym, logic lvl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0 && !gaps_off)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push        <= 1'b1;
        req_type    <= req;
        symbol_code <= sym;
        mark_level  <= lvl;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (sb.predict_request(req, sym, lvl))
            items_done++;
    endtask

    task send_tick();
        offer_request(REQ_TICK, DATA_BITS'($urandom), 1'($urandom));
    endtask

    task send_control(req_code_t req);
        offer_request(req, DATA_BITS'($urandom), 1'($urandom));
    endtask

    task enqueue_random();
        if ($urandom_range(0, 3) == 0)
            offer_request(REQ_ENQ_BIT, DATA_BITS'($urandom), 1'($urandom));
        else
            offer_request(REQ_ENQ_SYMBOL, DATA_BITS'($urandom), 1'($urandom));
    endtask

    task offer_noise();
        offer_request(3'($urandom_range(0, 7)), DATA_BITS'($urandom), 1'($urandom));
    endtask

    // stop offering, let every predicted item drain, then let the block go quiet
    task settle_block();
        int waited;
        push  <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (sb.pending() != 0 && waited < DRAIN_LIMIT);
        if (sb.pending() != 0)
            sb.flush_missing();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes, one per handshake, selected by mask bit = index
    task program_regs(logic [31:0] mk, logic [31:0] sp, logic [31:0] spb,
                      logic [1:0] stop, logic [3:0] which);
        cfg_idx_t    order [4];
        logic [31:0] vals [4];
        order[0] = CFG_MARK_STEP;
        order[1] = CFG_SPACE_STEP;
        order[2] = CFG_SPB;
        order[3] = CFG_STOP_LEN;
        vals[0]  = mk;
        vals[1]  = sp;
        vals[2]  = spb;
        vals[3]  = {$urandom} & ~32'h3 | {30'd0, stop};
        for (int i = 0; i < 4; i++)
        begin
            if (which[i])
            begin
                cfg_valid <= 1'b1;
                cfg_index <= order[i];
                cfg_data  <= vals[i];
                @(posedge clk);
                while (!cfg_ready)
                    @(posedge clk);
                sb.apply_register(order[i], vals[i]);
                reg_writes++;
            end
        end
        if (which != 0)
            cfg_valid <= 1'b0;
    endtask

    function logic [31:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return STEP_MAX;
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] pick_spb();
        case ($urandom_range(0, 9))
            0:       return SPB_ONE_SAMPLE;
            1:       return SPB_ONE_SAMPLE + 32'($urandom_range(0, 65535));
            default: return SPB_ONE_SAMPLE + 32'($urandom_range(0, 5 * 65536));
        endcase
    endfunction

    // extremes, every request, idle mark, tail, restart, stop
    task run_directed();
        program_regs($urandom, $urandom, SPB_ONE_SAMPLE, UNITS_ONE, 4'b1111);
        send_tick();
        offer_request(REQ_UNKNOWN_LO, '1, 1'b1);
        offer_request(REQ_UNKNOWN_HI, '0, 1'b0);
        send_control(REQ_START);
        send_tick();
        send_tick();
        offer_request(REQ_ENQ_SYMBOL, '1, 1'b0);
        offer_request(REQ_ENQ_BIT, '0, 1'b0);
        repeat (10) send_tick();
        send_tick();
        send_control(REQ_START);
        offer_request(REQ_ENQ_SYMBOL, '0, 1'b1);
        send_tick();
        send_tick();
        send_control(REQ_START);
        send_tick();
        send_control(REQ_STOP);
        send_tick();
    endtask

    // overfill the cell queue, then hold the receiver while ticks keep coming
    task run_full_queue();
        int n;
        settle_block();
        program_regs('0, '0, SPB_ONE_SAMPLE + 32'($urandom_range(0, 32767)),
                     UNITS_TWO, 4'b1100);
        send_control(REQ_STOP);
        repeat (37) offer_request(REQ_ENQ_SYMBOL, DATA_BITS'($urandom), 1'($urandom));
        repeat (5) offer_request(REQ_ENQ_BIT, DATA_BITS'($urandom), 1'($urandom));
        send_control(REQ_START);
        gaps_off   = 1'b1;
        hold_left <= PRESSURE_HOLD;
        n          = 0;
        while (sb.running && n < 2000)
        begin
            send_tick();
            n++;
        end
        gaps_off = 1'b0;
        settle_block();
    endtask

    // largest bit time: only a few samples of one frame
    task run_slow_bit_rate();
        settle_block();
        program_regs(pick_step(), pick_step(), SPB_MAX, 2'($urandom_range(0, 3)), 4'b1111);
        send_control(REQ_STOP);
        enqueue_random();
        send_control(REQ_START);
        repeat (40) send_tick();
        send_control(REQ_STOP);
    endtask

    // one transmission with random settings, mostly well formed
    task run_transmission();
        int n_pre;
        int n_ticks;
        int extra;
        int pick;
        bit idle_first;
        settle_block();
        program_regs(pick_step(), pick_step(), pick_spb(), 2'($urandom_range(0, 3)),
                     4'($urandom_range(1, 15)));
        if ($urandom_range(0, 3) == 0)
            send_control(REQ_STOP);
        idle_first = ($urandom_range(0, 3) == 0);
        n_pre      = idle_first ? 0 : $urandom_range(1, 3);
        repeat (n_pre) enqueue_random();
        send_control(REQ_START);
        if (idle_first)
        begin
            repeat ($urandom_range(1, 6)) send_tick();
            repeat ($urandom_range(1, 3)) enqueue_random();
        end
        n_ticks = 0;
        extra   = 0;
        while (sb.running && n_ticks < 400)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 8 && extra < 6)
            begin
                enqueue_random();
                extra++;
            end
            else if (pick < 14)
                offer_noise();
            else if (pick == 14)
                send_control(REQ_START);
            else
            begin
                send_tick();
                n_ticks++;
            end
        end
        if (sb.running)
            send_control(REQ_STOP);
        repeat ($urandom_range(0, 2)) send_tick();
    endtask

    // main sequence
    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_full_queue();
        while (items_done < ITEM_TARGET)
        begin
            if (phase_no == SLOW_PHASE)
                run_slow_bit_rate();
            else
                run_transmission();
            phase_no++;
        end
        settle_block();
        $display("covered %0d requests over %0d random phases with %0d register writes",
                 items_done, phase_no, reg_writes);
        $display("checked %0d samples, %0d completions; full queue refused %0d frames, %0d cells",
                 sb.samples_checked, sb.completions_checked, sb.frames_dropped,
                 sb.cells_dropped);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d items still expected", sb.pending());
        $display("simulation failed");
        $finish;
    end

endmodule
